@@ rtl/rvx_pkg.sv @@
// rvx_pkg: shared types, status codes and opcode constants for the RV32I execute core.
// No dependencies; imported by every module in rtl/.
package rvx_pkg;

   localparam int DMEM_BYTES_DEF = 65536;
   localparam logic [31:0] CONSOLE_RESET = 32'h0000_5000;

   // RV32I major opcodes
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // funct3 codes used by more than one place
   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   // CSR register map
   localparam logic [2:0] CSR_CONSOLE = 3'd0;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EBREAK   = 3'd1,
      ST_ILLEGAL  = 3'd2,
      ST_RANGE    = 3'd3,
      ST_MISALIGN = 3'd4
   } status_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] instruction;
      logic [15:0] preload_address;
      logic [31:0] preload_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [19:0] fetch_address;
      logic        reg_write_valid;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        console_valid;
      logic [7:0]  console_char;
   } rsp_type;

   // outcome of executing one item
   typedef struct packed {
      status_type  status;
      logic        pc_we;
      logic [31:0] npc;
      logic        halt_we;
      logic        wr_en;
      logic [31:0] wr_val;
      logic        con_v;
      logic [7:0]  con_c;
      logic        mem_rd;
      logic        mem_wr;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size_m1;
      logic [31:0] mem_wdata;
   } exec_res_type;

   // data memory request
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [1:0]  size_m1;
      logic [31:0] wdata;
   } dmem_req_type;

endpackage

@@ rtl/rvx_regfile.sv @@
// rvx_regfile: 32x32 register memory, two registered read ports, one write port.
// Depends on rvx_pkg (none of its types, imported for house consistency).
module rvx_regfile
   import rvx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [4:0]  raddr1,
   input  logic [4:0]  raddr2,
   output logic [31:0] rdata1,
   output logic [31:0] rdata2,
   input  logic        we,
   input  logic [4:0]  waddr,
   input  logic [31:0] wdata
);

   logic [31:0] mem [32];
   logic [31:0] vld_ff, vld_in;
   logic [31:0] raw1_ff, raw2_ff;
   logic        hit1_ff, hit2_ff;

   // entries read as zero until first written; x0 is never written
   always_comb begin
      vld_in = vld_ff;
      if (we) vld_in[waddr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // memory: read-before-write, caller forwards same-cycle writes
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      raw1_ff <= mem[raddr1];
      raw2_ff <= mem[raddr2];
      hit1_ff <= vld_ff[raddr1];
      hit2_ff <= vld_ff[raddr2];
   end

   assign rdata1 = hit1_ff ? raw1_ff : '0;
   assign rdata2 = hit2_ff ? raw2_ff : '0;

endmodule

@@ rtl/rvx_dmem.sv @@
// rvx_dmem: byte-addressed data memory as four byte lanes, unaligned 1/2/4-byte access.
// Depends on rvx_pkg (dmem_req_type). Runs a clearing pass after reset.
module rvx_dmem
   import rvx_pkg::*;
#(
   parameter int DMEM_BYTES = DMEM_BYTES_DEF
)(
   input  logic                          clock,
   input  logic                          reset,
   input  dmem_req_type                  req,
   input  logic [$clog2(DMEM_BYTES)-1:0] addr,
   output logic [31:0]                   rdata,
   output logic                          busy
);

   localparam int AW   = $clog2(DMEM_BYTES);
   localparam int ROWS = DMEM_BYTES / 4;
   localparam int RW   = $clog2(ROWS);

   logic          clr_ff;
   logic [RW-1:0] clr_cnt_ff;
   logic [1:0]    off_ff;
   logic [7:0]    lane_rd [4];
   logic [RW-1:0] base;

   // clearing pass: one row of all lanes per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == RW'(ROWS - 1)) clr_ff <= 1'b0;
      end
   end

   assign busy = clr_ff;
   assign base = addr[AW-1:2];

   always_ff @(posedge clock) begin
      if (req.rd) off_ff <= addr[1:0];
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [7:0]    mem [ROWS];
      logic [1:0]    j;
      logic [RW-1:0] row;
      logic          en;
      logic [7:0]    wbyte;
      logic [7:0]    rd_ff;

      // lane k holds byte j of the access
      always_comb begin
         j     = 2'(k) - addr[1:0];
         row   = base + RW'(2'(k) < addr[1:0]);
         en    = j <= req.size_m1;
         wbyte = req.wdata[8*j +: 8];
      end

      always_ff @(posedge clock) begin
         if (clr_ff) begin
            mem[clr_cnt_ff] <= '0;
         end else if (req.wr && en) begin
            mem[row] <= wbyte;
         end
         rd_ff <= mem[row];
      end

      assign lane_rd[k] = rd_ff;
   end

   // reassemble bytes in access order
   always_comb begin
      for (int jj = 0; jj < 4; jj++) begin
         rdata[8*jj +: 8] = lane_rd[2'(off_ff + 2'(jj))];
      end
   end

endmodule

@@ rtl/rvx_exec.sv @@
// rvx_exec: combinational decode and execute of one item (ALU, branch, address, range).
// Depends on rvx_pkg (req_type, exec_res_type, status_type, opcode constants).
module rvx_exec
   import rvx_pkg::*;
#(
   parameter int DMEM_BYTES = DMEM_BYTES_DEF
)(
   input  req_type      item,
   input  logic [31:0]  a,
   input  logic [31:0]  b,
   input  logic [31:0]  pc,
   input  status_type   halt,
   input  logic [31:0]  console,
   output exec_res_type res
);

   logic [31:0] w, ii, is, ib, ij, op2, ad, alu, pre_a;
   logic [6:0]  op, f7;
   logic [2:0]  f3;
   logic [4:0]  sh;
   logic        ok, rng, brk, take, alt, inr;
   logic [32:0] last;

   always_comb begin
      w   = item.instruction;
      op  = w[6:0];
      f3  = w[14:12];
      f7  = w[31:25];
      ii  = {{20{w[31]}}, w[31:20]};
      is  = {{20{w[31]}}, w[31:25], w[11:7]};
      ib  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      ij  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      op2 = (op == OP_REG) ? b : ii;
      sh  = op2[4:0];
      alt = f7 == F7_ALT;
      ad  = a + ((op == OP_STORE) ? is : ii);
      pre_a = {16'b0, item.preload_address[15:2], 2'b00};

      res = '0;
      res.status = ST_OK;
      res.npc = pc;
      ok = 1'b1; rng = 1'b0; brk = 1'b0; take = 1'b0;
      alu = '0; last = '0; inr = 1'b0;

      // shared ALU for register and immediate forms
      case (f3)
         3'd0: alu = (op == OP_REG && alt) ? a - op2 : a + op2;
         3'd1: alu = a << sh;
         3'd2: alu = {31'b0, $signed(a) < $signed(op2)};
         3'd3: alu = {31'b0, a < op2};
         3'd4: alu = a ^ op2;
         3'd5: alu = alt ? 32'($signed(a) >>> sh) : a >> sh;
         3'd6: alu = a | op2;
         default: alu = a & op2;
      endcase

      if (item.mode) begin
         // preload: aligned word, dropped when it does not fit
         last = {1'b0, pre_a} + 33'd3;
         res.mem_wr = last < 33'(DMEM_BYTES);
         res.mem_addr = pre_a;
         res.mem_size_m1 = 2'd3;
         res.mem_wdata = item.preload_word;
      end else if (halt != ST_OK) begin
         res.status = halt;
      end else if (pc[1:0] != 2'b00) begin
         res.status = ST_MISALIGN;
         res.halt_we = 1'b1;
      end else begin
         res.npc = pc + 32'd4;
         unique case (op)
            OP_LUI: begin
               res.wr_en = 1'b1; res.wr_val = {w[31:12], 12'b0};
            end
            OP_AUIPC: begin
               res.wr_en = 1'b1; res.wr_val = pc + {w[31:12], 12'b0};
            end
            OP_JAL: begin
               res.wr_en = 1'b1; res.wr_val = pc + 32'd4; res.npc = pc + ij;
            end
            OP_JALR: begin
               res.wr_en = 1'b1; res.wr_val = pc + 32'd4;
               res.npc = (a + ii) & ~32'd1;
            end
            OP_BRANCH: begin
               case (f3)
                  3'd0: take = a == b;
                  3'd1: take = a != b;
                  3'd4: take = $signed(a) < $signed(b);
                  3'd5: take = !($signed(a) < $signed(b));
                  3'd6: take = a < b;
                  3'd7: take = a >= b;
                  default: ok = 1'b0;
               endcase
               if (take) res.npc = pc + ib;
            end
            OP_LOAD: begin
               case (f3) inside
                  F3_B, F3_BU: res.mem_size_m1 = 2'd0;
                  F3_H, F3_HU: res.mem_size_m1 = 2'd1;
                  F3_W:        res.mem_size_m1 = 2'd3;
                  default:     ok = 1'b0;
               endcase
               res.mem_rd = 1'b1;
            end
            OP_STORE: begin
               case (f3) inside
                  F3_B:    res.mem_size_m1 = 2'd0;
                  F3_H:    res.mem_size_m1 = 2'd1;
                  F3_W:    res.mem_size_m1 = 2'd3;
                  default: ok = 1'b0;
               endcase
               res.mem_wr = 1'b1;
               res.mem_wdata = b;
               res.con_v = ad == console;
               res.con_c = b[7:0];
            end
            OP_IMM, OP_REG: begin
               res.wr_en = 1'b1;
               res.wr_val = alu;
               if (f3 == 3'd5 && f7 != F7_BASE && !alt) ok = 1'b0;
               if (op == OP_REG && f3 == 3'd0 && f7 != F7_BASE && !alt) ok = 1'b0;
            end
            OP_SYSTEM: brk = 1'b1;
            default: ok = 1'b0;
         endcase

         // data access range: last byte must lie inside the memory
         res.mem_addr = ad;
         last = {1'b0, ad} + {31'b0, res.mem_size_m1};
         inr  = last < 33'(DMEM_BYTES);
         rng  = (res.mem_rd || res.mem_wr) && !inr;

         if (!ok) begin
            res.status = ST_ILLEGAL;
         end else if (brk) begin
            res.status = ST_EBREAK;
         end else if (rng) begin
            res.status = ST_RANGE;
         end
         if (!ok || brk || rng) begin
            res.halt_we = ok;
            res.wr_en = 1'b0; res.mem_rd = 1'b0; res.mem_wr = 1'b0;
            res.con_v = 1'b0; res.con_c = '0;
            res.npc = pc;
         end else begin
            res.pc_we = 1'b1;
         end
         if (!res.con_v) res.con_c = '0;
      end
   end

endmodule

@@ rtl/rvx_execute_top_dummy_never.sv @@
// stage: holds the item between acceptance and execution and drives its read addresses.
// Depends on rvx_pkg (req_type).
module rvx_execute_top_dummy_never
   import rvx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic        drain,
   input  req_type     din,
   output req_type     dout,
   output logic        valid,
   output logic [4:0]  rs1,
   output logic [4:0]  rs2
);

   logic    vld_ff;
   req_type item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= 1'b1;
      end else if (drain) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) item_ff <= din;
   end

   // register read address follows the item that executes next
   assign rs1   = load ? din.instruction[19:15] : item_ff.instruction[19:15];
   assign rs2   = load ? din.instruction[24:20] : item_ff.instruction[24:20];
   assign dout  = item_ff;
   assign valid = vld_ff;

endmodule

@@ rtl/rv32i_execute_core.sv @@
// rv32i_execute_core: top level of the RV32I execute core with CSR port.
// Depends on rvx_pkg, rvx_regfile, rvx_dmem, rvx_exec, rvx_execute_top_dummy_never.

// ALU, branch, jump, store and preload items are taken one per cycle unless the
// output register or the memory clear holds them back; a load holds back the next
// item until its data is written, as the data memory read is registered. Register
// reads come from a two-port register memory with same-cycle write forwarding.
// After reset the data memory is swept clear while req_ready stays low; CSR writes
// are taken throughout. Results wait in an output register so the next item may
// enter while a result is not yet taken.
module rv32i_execute_core
   import rvx_pkg::*;
#(
   parameter int DMEM_BYTES = DMEM_BYTES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(DMEM_BYTES);

   logic         s1_valid, s1_load, exec_fire, out_free, ld_done, busy;
   req_type      s1_item;
   logic [4:0]   rs1, rs2;
   logic [31:0]  rd1, rd2, opa, opb, ld_raw, ld_val;
   exec_res_type e;
   logic [4:0]   rd;

   logic [31:0]  pc_ff, console_ff;
   status_type   halt_ff;
   logic         ld_pend_ff;
   logic [2:0]   ld_f3_ff;
   logic [4:0]   ld_rd_ff;
   logic [AW-1:0] ld_addr_ff;
   logic [1:0]   ld_size_ff;
   logic         wb_valid_ff;
   logic [4:0]   wb_idx_ff;
   logic [31:0]  wb_val_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff, rsp_in;

   logic         rf_we;
   logic [4:0]   rf_waddr;
   logic [31:0]  rf_wdata;
   dmem_req_type dm_req;
   logic [AW-1:0] dm_addr;

   // CSR port: single register, zero-wait
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_CONSOLE[2]) ? console_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         console_ff <= CONSOLE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == CSR_CONSOLE[2]) begin
         console_ff <= csr_pwdata;
      end
   end

   // handshake and stage control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec_fire = s1_valid && !ld_pend_ff && out_free && !busy;
   assign ld_done   = ld_pend_ff && out_free;
   assign req_ready = !busy && (!s1_valid || exec_fire);
   assign s1_load   = req_valid && req_ready;

   rvx_execute_top_dummy_never u_stage (
      .clock (clock),
      .reset (reset),
      .load  (s1_load),
      .drain (exec_fire),
      .din   (req_data),
      .dout  (s1_item),
      .valid (s1_valid),
      .rs1   (rs1),
      .rs2   (rs2)
   );

   rvx_regfile u_rf (
      .clock  (clock),
      .reset  (reset),
      .raddr1 (rs1),
      .raddr2 (rs2),
      .rdata1 (rd1),
      .rdata2 (rd2),
      .we     (rf_we),
      .waddr  (rf_waddr),
      .wdata  (rf_wdata)
   );

   // forward the write made at the previous edge
   assign opa = (wb_valid_ff && wb_idx_ff == s1_item.instruction[19:15]) ? wb_val_ff : rd1;
   assign opb = (wb_valid_ff && wb_idx_ff == s1_item.instruction[24:20]) ? wb_val_ff : rd2;

   rvx_exec #(.DMEM_BYTES(DMEM_BYTES)) u_exec (
      .item    (s1_item),
      .a       (opa),
      .b       (opb),
      .pc      (pc_ff),
      .halt    (halt_ff),
      .console (console_ff),
      .res     (e)
   );

   assign rd = s1_item.instruction[11:7];

   // data memory request: executing item, or hold the pending load read
   always_comb begin
      dm_req = '0;
      dm_addr = ld_addr_ff;
      if (exec_fire) begin
         dm_req.rd      = e.mem_rd;
         dm_req.wr      = e.mem_wr;
         dm_req.size_m1 = e.mem_size_m1;
         dm_req.wdata   = e.mem_wdata;
         dm_addr        = e.mem_addr[AW-1:0];
      end else if (ld_pend_ff) begin
         dm_req.rd      = 1'b1;
         dm_req.size_m1 = ld_size_ff;
      end
   end

   rvx_dmem #(.DMEM_BYTES(DMEM_BYTES)) u_dmem (
      .clock (clock),
      .reset (reset),
      .req   (dm_req),
      .addr  (dm_addr),
      .rdata (ld_raw),
      .busy  (busy)
   );

   // load data extension
   always_comb begin
      case (ld_f3_ff)
         F3_B:    ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
         F3_H:    ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
         F3_BU:   ld_val = {24'b0, ld_raw[7:0]};
         F3_HU:   ld_val = {16'b0, ld_raw[15:0]};
         default: ld_val = ld_raw;
      endcase
   end

   // register write port
   always_comb begin
      rf_we = 1'b0; rf_waddr = ld_rd_ff; rf_wdata = ld_val;
      if (ld_done) begin
         rf_we = ld_rd_ff != 5'd0;
      end else if (exec_fire) begin
         rf_we = e.wr_en && rd != 5'd0;
         rf_waddr = rd;
         rf_wdata = e.wr_val;
      end
   end

   // result assembly
   always_comb begin
      rsp_in = '0;
      if (ld_done) begin
         rsp_in.status          = ST_OK;
         rsp_in.fetch_address   = pc_ff[19:0];
         rsp_in.reg_write_valid = rf_we;
         rsp_in.reg_write_index = rf_we ? ld_rd_ff : '0;
         rsp_in.reg_write_value = rf_we ? ld_val : '0;
      end else begin
         rsp_in.status          = e.status;
         rsp_in.fetch_address   = e.pc_we ? e.npc[19:0] : pc_ff[19:0];
         rsp_in.reg_write_valid = rf_we;
         rsp_in.reg_write_index = rf_we ? rd : '0;
         rsp_in.reg_write_value = rf_we ? e.wr_val : '0;
         rsp_in.console_valid   = e.con_v;
         rsp_in.console_char    = e.con_c;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         halt_ff      <= ST_OK;
         ld_pend_ff   <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wb_valid_ff <= rf_we;
         if (exec_fire) begin
            if (e.pc_we) pc_ff <= e.npc;
            if (e.halt_we) halt_ff <= e.status;
            ld_pend_ff <= e.mem_rd;
         end else if (ld_done) begin
            ld_pend_ff <= 1'b0;
         end
         if ((exec_fire && !e.mem_rd) || ld_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wb_idx_ff <= rf_waddr;
      wb_val_ff <= rf_wdata;
      if (exec_fire) begin
         ld_f3_ff   <= s1_item.instruction[14:12];
         ld_rd_ff   <= rd;
         ld_addr_ff <= e.mem_addr[AW-1:0];
         ld_size_ff <= e.mem_size_m1;
      end
      if ((exec_fire && !e.mem_rd) || ld_done) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a halted core keeps its pc
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      halt_ff != ST_OK |=> pc_ff == $past(pc_ff))
      else $error("pc moved while halted");

   // x0 is never written
   a_no_x0: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> rf_waddr != 5'd0)
      else $error("write to x0");

   // a pending load completes as soon as the output slot frees
   a_ld_done: assert property (@(posedge clock) disable iff (reset)
      ld_pend_ff && out_free |=> !ld_pend_ff || $past(exec_fire))
      else $error("load stuck pending");

   // no result and no item while the memory is being cleared
   a_clear: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready && !exec_fire)
      else $error("activity during memory clear");

endmodule

@@ test/rv32i_execute_core_checker.sv @@
// Checker for rv32i_execute_core: watches request, result and CSR transfers,
// keeps its own copy of the core state and compares every result in order.
// Depends on rvx_pkg for the payload types, opcodes and status codes.
module rv32i_execute_core_checker
   import rvx_pkg::*;
#(
   parameter int MEM_BYTES = DMEM_BYTES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // branch conditions
   localparam logic [2:0] BR_EQ = 3'd0, BR_NE = 3'd1, BR_LT = 3'd4;
   localparam logic [2:0] BR_GE = 3'd5, BR_LTU = 3'd6, BR_GEU = 3'd7;
   // ALU operations
   localparam logic [2:0] ALU_ADD = 3'd0, ALU_SLL = 3'd1, ALU_SLT = 3'd2, ALU_SLTU = 3'd3;
   localparam logic [2:0] ALU_XOR = 3'd4, ALU_SHR = 3'd5, ALU_OR = 3'd6, ALU_AND = 3'd7;

   logic [31:0] gpr [32];
   logic [31:0] pc;
   logic [7:0]  mem [MEM_BYTES];
   status_type  halt_cause;
   logic [31:0] console_addr;
   rsp_type     expected_q [$];
   int          fail_cnt;

   function automatic bit fits(logic [31:0] addr, int n);
      return (longint'(addr) + n - 1) < MEM_BYTES;
   endfunction

   // one item against the shadow state
   function automatic rsp_type run_item(req_type r);
      logic [6:0]  op, f7;
      logic [2:0]  f3;
      logic [4:0]  rd, sh;
      logic [31:0] w, a, b, ii, is, ib, ij, res, npc, ad;
      int          n;
      bit          ok, wr, taken;
      status_type  st;
      rsp_type     o;
      w = r.instruction;
      o = '0;
      st = ST_OK;
      wr = 0;
      if (r.mode) begin
         ad = {16'h0, r.preload_address[15:2], 2'b00};
         if (fits(ad, 4))
            for (int k = 0; k < 4; k++) mem[ad + k] = r.preload_word[8*k +: 8];
      end else if (halt_cause != ST_OK) begin
         st = halt_cause;
      end else if (pc[1:0] != 2'b00) begin
         halt_cause = ST_MISALIGN;
         st = ST_MISALIGN;
      end else begin
         op = w[6:0];
         f3 = w[14:12];
         f7 = w[31:25];
         rd = w[11:7];
         a = gpr[w[19:15]];
         b = gpr[w[24:20]];
         ii = {{20{w[31]}}, w[31:20]};
         is = {{20{w[31]}}, w[31:25], w[11:7]};
         ib = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
         ij = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
         res = '0;
         npc = pc + 4;
         ok = 1;
         case (op)
            OP_LUI: begin
               res = {w[31:12], 12'h0};
               wr = 1;
            end
            OP_AUIPC: begin
               res = pc + {w[31:12], 12'h0};
               wr = 1;
            end
            OP_JAL: begin
               res = pc + 4;
               wr = 1;
               npc = pc + ij;
            end
            OP_JALR: begin
               res = pc + 4;
               wr = 1;
               npc = (a + ii) & ~32'h1;
            end
            OP_BRANCH: begin
               taken = 0;
               case (f3)
                  BR_EQ:   taken = a == b;
                  BR_NE:   taken = a != b;
                  BR_LT:   taken = $signed(a) < $signed(b);
                  BR_GE:   taken = !($signed(a) < $signed(b));
                  BR_LTU:  taken = a < b;
                  BR_GEU:  taken = a >= b;
                  default: ok = 0;
               endcase
               if (taken) npc = pc + ib;
            end
            OP_LOAD: begin
               ad = a + ii;
               case (f3)
                  F3_B, F3_BU: n = 1;
                  F3_H, F3_HU: n = 2;
                  F3_W:        n = 4;
                  default:     n = 0;
               endcase
               if (n == 0) ok = 0;
               else if (!fits(ad, n)) st = ST_RANGE;
               else begin
                  for (int k = 0; k < n; k++) res[8*k +: 8] = mem[ad + k];
                  if (f3 == F3_B) res = {{24{res[7]}}, res[7:0]};
                  if (f3 == F3_H) res = {{16{res[15]}}, res[15:0]};
                  wr = 1;
               end
            end
            OP_STORE: begin
               ad = a + is;
               case (f3)
                  F3_B:    n = 1;
                  F3_H:    n = 2;
                  F3_W:    n = 4;
                  default: n = 0;
               endcase
               if (n == 0) ok = 0;
               else if (!fits(ad, n)) st = ST_RANGE;
               else begin
                  for (int k = 0; k < n; k++) mem[ad + k] = b[8*k +: 8];
                  if (ad == console_addr) begin
                     o.console_valid = 1;
                     o.console_char = b[7:0];
                  end
               end
            end
            OP_IMM, OP_REG: begin
               if (op == OP_REG) ii = b;
               sh = ii[4:0];
               wr = 1;
               case (f3)
                  ALU_ADD: begin
                     if (op == OP_IMM || f7 == F7_BASE) res = a + ii;
                     else if (f7 == F7_ALT) res = a - ii;
                     else ok = 0;
                  end
                  ALU_SLL:  res = a << sh;
                  ALU_SLT:  res = {31'h0, $signed(a) < $signed(ii)};
                  ALU_SLTU: res = {31'h0, a < ii};
                  ALU_XOR:  res = a ^ ii;
                  ALU_SHR: begin
                     if (f7 == F7_ALT) res = $signed(a) >>> sh;
                     else if (f7 == F7_BASE) res = a >> sh;
                     else ok = 0;
                  end
                  ALU_OR:   res = a | ii;
                  default:  res = a & ii;
               endcase
            end
            OP_SYSTEM: st = ST_EBREAK;
            default: ok = 0;
         endcase
         if (!ok) begin
            st = ST_ILLEGAL;
            wr = 0;
            o.console_valid = 0;
            o.console_char = '0;
         end else if (st != ST_OK) begin
            halt_cause = st;
            wr = 0;
         end else begin
            if (wr && rd != 0) begin
               gpr[rd] = res;
               o.reg_write_index = rd;
               o.reg_write_value = res;
            end else wr = 0;
            pc = npc;
         end
      end
      o.status = st;
      o.fetch_address = pc[19:0];
      o.reg_write_valid = wr;
      return o;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %h, got %h", name, exp, act);
         fail_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (gpr[i]) gpr[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         pc = '0;
         halt_cause = ST_OK;
         console_addr = CONSOLE_RESET;
         expected_q.delete();
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == 3'(CSR_CONSOLE << 2))
            console_addr = csr_pwdata;
         // result transfer
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_cnt++;
            end else begin
               e = expected_q.pop_front();
               check_field("status", e.status, rsp_data.status);
               check_field("fetch_address", e.fetch_address, rsp_data.fetch_address);
               check_field("reg_write_valid", e.reg_write_valid, rsp_data.reg_write_valid);
               check_field("reg_write_index", e.reg_write_index, rsp_data.reg_write_index);
               check_field("reg_write_value", e.reg_write_value, rsp_data.reg_write_value);
               check_field("console_valid", e.console_valid, rsp_data.console_valid);
               check_field("console_char", e.console_char, rsp_data.console_char);
            end
         end
         // request transfer
         if (req_valid && req_ready) expected_q.push_back(run_item(req_data));
      end
      pending <= expected_q.size();
      failures <= fail_cnt;
   end

   initial begin
      fail_cnt = 0;
      failures = 0;
      pending = 0;
   end
endmodule

@@ test/tb_rv32i_execute_core.sv @@
// Testbench top for rv32i_execute_core: clock, reset, instruction/preload
// stimulus, CSR writes and the verdict. Depends on rvx_pkg and the checker.
module tb_rv32i_execute_core;
   import rvx_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] BR_RSV_A = 3'd2, BR_RSV_B = 3'd3;
   localparam logic [2:0] F3_ADDSUB = 3'd0, F3_SHR = 3'd5, F3_SLL = 3'd1;
   // base registers for memory accesses, never random destinations
   localparam logic [4:0] X_CON = 5'd28, X_ZB = 5'd29, X_MID = 5'd30, X_HI = 5'd31;
   localparam logic [4:0] X_TOP = 5'd27;

   logic        clock, reset;
   logic        req_valid, req_ready, rsp_valid, rsp_ready;
   req_type     req_data;
   rsp_type     rsp_data;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int          failures, pending;
   bit          idle_on;
   int          stall_left;

   rv32i_execute_core dut (.*);

   rv32i_execute_core_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .failures, .pending);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // encoders
   function automatic logic [31:0] enc_i(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, op};
   endfunction
   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OP_REG};
   endfunction
   function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction
   function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [12:0] imm);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction
   function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   function automatic req_type exec_item(logic [31:0] w);
      req_type r;
      r = '0;
      r.instruction = w;
      r.preload_address = 16'($urandom);
      r.preload_word = $urandom;
      return r;
   endfunction

   function automatic req_type preload_item(logic [15:0] addr, logic [31:0] word);
      req_type r;
      r.mode = 1'b1;
      r.instruction = $urandom;
      r.preload_address = addr;
      r.preload_word = word;
      return r;
   endfunction

   function automatic logic [4:0] rand_base();
      logic [4:0] b;
      case ($urandom_range(0, 4))
         0: b = 5'd0;
         1: b = X_CON;
         2: b = X_ZB;
         3: b = X_MID;
         default: b = X_HI;
      endcase
      return b;
   endfunction

   // encoding that the core rejects
   function automatic logic [31:0] illegal_word();
      logic [31:0] w;
      logic [6:0]  op, f7;
      logic [2:0]  f3;
      w = $urandom;
      case ($urandom_range(0, 4))
         0: begin
            do op = 7'($urandom);
            while (op inside {OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD,
                              OP_STORE, OP_IMM, OP_REG, OP_SYSTEM});
            w[6:0] = op;
         end
         1: w = {w[31:15], ($urandom_range(0, 1) ? BR_RSV_A : BR_RSV_B), w[11:7], OP_BRANCH};
         2: begin
            do f3 = 3'($urandom);
            while (f3 inside {F3_B, F3_H, F3_W, F3_BU, F3_HU});
            w = {w[31:15], f3, w[11:7], OP_LOAD};
         end
         3: w = {w[31:15], 3'($urandom_range(3, 7)), w[11:7], OP_STORE};
         default: begin
            do f7 = 7'($urandom);
            while (f7 inside {F7_BASE, F7_ALT});
            if ($urandom_range(0, 1))
               w = {f7, w[24:15], F3_SHR, w[11:7], OP_IMM};
            else
               w = {f7, w[24:15], ($urandom_range(0, 1) ? F3_SHR : F3_ADDSUB), w[11:7], OP_REG};
         end
      endcase
      return w;
   endfunction

   // mostly well-formed instructions that keep the core running
   function automatic req_type random_item();
      logic [31:0] w;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [11:0] off;
      int          pick;
      rd = 5'($urandom_range(0, 26));
      w = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 8) return preload_item(16'($urandom_range(0, 65532)), $urandom);
      if (pick < 14) return exec_item(illegal_word());
      off = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 7)) : 12'($urandom_range(0, 2047));
      if (pick < 18) w = {w[31:12], rd, OP_LUI};
      else if (pick < 21) w = {w[31:12], rd, OP_AUIPC};
      else if (pick < 36) begin
         f3 = 3'($urandom);
         if (f3 == F3_SHR) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         w = {w[31:12], rd, OP_IMM};
         w[14:12] = f3;
      end else if (pick < 52) begin
         f3 = 3'($urandom);
         if (f3 == F3_SHR || f3 == F3_ADDSUB)
            w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         w = enc_r(w[31:25], w[24:20], w[19:15], f3, rd);
      end else if (pick < 62) begin
         do f3 = 3'($urandom);
         while (f3 inside {BR_RSV_A, BR_RSV_B});
         w = enc_b(f3, w[19:15], w[24:20], {w[31:21], 2'b00});
      end else if (pick < 66) w = enc_j(rd, {w[31:13], 2'b00});
      else if (pick < 70) w = enc_i(OP_JALR, 3'($urandom), rd, 5'd0, {w[31:22], 2'b00} & 12'h7fc);
      else if (pick < 84) begin
         case ($urandom_range(0, 4))
            0: f3 = F3_B;
            1: f3 = F3_H;
            2: f3 = F3_W;
            3: f3 = F3_BU;
            default: f3 = F3_HU;
         endcase
         w = enc_i(OP_LOAD, f3, rd, rand_base(), off);
      end else begin
         case ($urandom_range(0, 2))
            0: f3 = F3_B;
            1: f3 = F3_H;
            default: f3 = F3_W;
         endcase
         w = enc_s(f3, rand_base(), w[24:20], off);
      end
      return exec_item(w);
   endfunction

   // one request transfer, with an optional idle burst in front
   task automatic send(req_type r);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock);
      while (!req_ready);
   endtask

   task automatic csr_write(logic [31:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(CSR_CONSOLE << 2);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // result side stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #2_000_000;
      $display("tb_rv32i_execute_core NOT OK");
      $finish;
   end

   initial begin
      logic [31:0] console_set [4];
      console_set = '{32'h0, 32'hffff_ffff, 32'h0000_5000, 32'h0000_f004};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_on = 1'b1;
      stall_left = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: base registers, ALU extremes, memory edges, control flow
      send(exec_item({20'h00005, X_CON, OP_LUI}));
      send(exec_item({20'h00008, X_MID, OP_LUI}));
      send(exec_item({20'h0000f, X_HI, OP_LUI}));
      send(exec_item({20'h00010, X_TOP, OP_LUI}));
      send(exec_item(enc_i(OP_IMM, F3_ADDSUB, 5'd1, 5'd0, 12'hfff)));
      send(exec_item(enc_i(OP_IMM, F3_ADDSUB, 5'd2, 5'd0, 12'h7ff)));
      for (int f = 0; f < 8; f++)
         send(exec_item(enc_r(F7_BASE, 5'd2, 5'd1, 3'(f), 5'(3 + f))));
      send(exec_item(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADDSUB, 5'd11)));
      send(exec_item(enc_r(F7_ALT, 5'd1, 5'd11, F3_SHR, 5'd12)));
      send(exec_item(enc_i(OP_IMM, F3_SHR, 5'd13, 5'd11, {F7_ALT, 5'd31})));
      send(exec_item(enc_i(OP_IMM, F3_SLL, 5'd14, 5'd1, {F7_BASE, 5'd31})));
      send(exec_item(enc_s(F3_W, X_CON, 5'd1, 12'h0)));
      send(preload_item(16'hfffc, 32'h8081_8283));
      send(exec_item(enc_i(OP_LOAD, F3_W, 5'd15, X_TOP, 12'hffc)));
      send(exec_item(enc_i(OP_LOAD, F3_B, 5'd16, X_TOP, 12'hfff)));
      send(exec_item(enc_i(OP_LOAD, F3_HU, 5'd17, X_TOP, 12'hffd)));
      send(exec_item(enc_b(3'd0, 5'd0, 5'd0, 13'd8)));
      send(exec_item(enc_j(5'd18, 21'h1ffff8)));
      send(exec_item(enc_i(OP_JALR, 3'd0, 5'd19, 5'd0, 12'h100)));
      send(exec_item({20'hfffff, 5'd20, OP_AUIPC}));
      send(exec_item(illegal_word()));

      // random phases, one console setting each
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         csr_write(console_set[p]);
         for (int k = 0; k < 230; k++) begin
            idle_on = !(p == 3 && k >= 130);
            send(random_item());
         end
      end

      // end with a halt, then items that must see it
      case ($urandom_range(0, 2))
         0: send(exec_item({25'($urandom_range(0, 33554431)), OP_SYSTEM}));
         1: send(exec_item(enc_i(OP_LOAD, F3_W, 5'd1, 5'd0, 12'hfff)));
         default: begin
            send(exec_item(enc_i(OP_JALR, 3'd0, 5'd0, 5'd0, 12'h002)));
            send(random_item());
         end
      endcase
      for (int k = 0; k < 6; k++) send(random_item());

      wait_idle();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("tb_rv32i_execute_core OK");
      else
         $display("tb_rv32i_execute_core NOT OK");
      $finish;
   end
endmodule
